// File: hdl/alt_pkg.sv
// Shared types, constants and byte-class functions for the array literal tokenizer.
// No dependencies; hdl files but alt_if.sv use scoped names, test files import it.
`default_nettype none
package alt_pkg;

	// parse states
	localparam logic [3:0] ST_BEGIN     = 4'd0;
	localparam logic [3:0] ST_FIRSTVAL  = 4'd1;
	localparam logic [3:0] ST_FINDVAL   = 4'd2;
	localparam logic [3:0] ST_BARE      = 4'd3;
	localparam logic [3:0] ST_QUOTED    = 4'd4;
	localparam logic [3:0] ST_QESC      = 4'd5;
	localparam logic [3:0] ST_FINDCOMMA = 4'd6;
	localparam logic [3:0] ST_FINISH    = 4'd7;
	localparam logic [3:0] ST_ERROR     = 4'd8;

	// error codes
	localparam logic [2:0] ERR_NONE          = 3'd0;
	localparam logic [2:0] ERR_BEFORE_BRACE  = 3'd1;
	localparam logic [2:0] ERR_NESTED        = 3'd2;
	localparam logic [2:0] ERR_EMPTY_ELEM    = 3'd3;
	localparam logic [2:0] ERR_ILLEGAL_START = 3'd4;
	localparam logic [2:0] ERR_BRACE_IN_VAL  = 3'd5;
	localparam logic [2:0] ERR_AFTER_VALUE   = 3'd6;
	localparam logic [2:0] ERR_AFTER_END     = 3'd7;

	// characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'd32;

	typedef struct packed {
		logic       is_data;
		logic       elem_begin;
		logic       elem_end;
		logic       closed;
		logic [2:0] error_code;
		logic       done_res;
	} tok_flags_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic logic bare_start_ok(input logic [7:0] c);
		logic ok;
		ok = 1'b1;
		if (c < CH_SPACE)
			ok = 1'b0;
		if (c == CH_DQUOTE || c == CH_SQUOTE)
			ok = 1'b0;
		if (c == CH_LBRACE || c == CH_RBRACE || c == CH_COMMA)
			ok = 1'b0;
		if (is_ws(c))
			ok = 1'b0;
		return ok;
	endfunction

endpackage
`default_nettype wire

// File: hdl/alt_if.sv
// Valid/ready stream interfaces: text bytes in, token results out.
// Standalone; no package dependency.
`default_nettype none
interface alt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source(output valid, text_byte, last_byte, input ready);
	modport sink(input valid, text_byte, last_byte, output ready);
endinterface

interface alt_tok_if #(
	parameter int COUNT_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [7:0]             data_byte;
	logic                   is_data;
	logic                   elem_begin;
	logic                   elem_end;
	logic [COUNT_WIDTH-1:0] elem_count;
	logic                   closed;
	logic [2:0]             error_code;
	logic                   done_res;

	modport source(output valid, data_byte, is_data, elem_begin, elem_end, elem_count,
		closed, error_code, done_res, input ready);
	modport sink(input valid, data_byte, is_data, elem_begin, elem_end, elem_count,
		closed, error_code, done_res, output ready);
endinterface
`default_nettype wire

// File: hdl/array_literal_tokenizer_core.sv
// Array literal tokenizer top level: input register, parser, result register.
// Depends on alt_pkg, alt_if.sv and alt_parser.
//
// Takes one byte of a one-level brace array literal per item and returns one result
// per byte. Throughput is one item per clock while tok_out is not stalled. A byte
// accepted into the input register moves into the result register once the output
// is free; its result then shows on tok_out. The rate is set by the parse-state
// register, which updates once per byte as the item moves from the input register
// into the result register. A stalled output holds both registers; the input keeps
// accepting as long as the input register is free or moving.
// last_byte ends a text and returns the parser to its reset state afterwards.
`default_nettype none
module array_literal_tokenizer_core #(
	parameter int COUNT_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	alt_byte_if.sink byte_in,
	alt_tok_if.source tok_out
);
	logic                   valid_s1;
	logic [7:0]             text_byte_s1;
	logic                   last_byte_s1;
	logic                   valid_s2;
	logic [7:0]             data_byte_s2;
	alt_pkg::tok_flags_t    flags_s2;
	logic [COUNT_WIDTH-1:0] elem_count_s2;
	alt_pkg::tok_flags_t    flags;
	logic [COUNT_WIDTH-1:0] elem_count;
	logic                   out_free, step, load;

	assign out_free      = !valid_s2 || tok_out.ready;
	assign step          = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || out_free;
	assign load          = byte_in.valid && byte_in.ready;

	alt_parser #(.COUNT_WIDTH(COUNT_WIDTH)) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.text_byte  (text_byte_s1),
		.last_byte  (last_byte_s1),
		.flags      (flags),
		.elem_count (elem_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (step)
				valid_s2 <= 1'b1;
			else if (tok_out.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			text_byte_s1 <= byte_in.text_byte;
			last_byte_s1 <= byte_in.last_byte;
		end
		if (step) begin
			data_byte_s2  <= text_byte_s1;
			flags_s2      <= flags;
			elem_count_s2 <= elem_count;
		end
	end

	assign tok_out.valid      = valid_s2;
	assign tok_out.data_byte  = data_byte_s2;
	assign tok_out.is_data    = flags_s2.is_data;
	assign tok_out.elem_begin = flags_s2.elem_begin;
	assign tok_out.elem_end   = flags_s2.elem_end;
	assign tok_out.elem_count = elem_count_s2;
	assign tok_out.closed     = flags_s2.closed;
	assign tok_out.error_code = flags_s2.error_code;
	assign tok_out.done_res   = flags_s2.done_res;
endmodule
`default_nettype wire

// File: hdl/alt_parser.sv
// Parse-state machine: per-byte decode, first-error latch and saturating element counter.
// Depends on alt_pkg.
`default_nettype none
module alt_parser #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             text_byte,
	input  wire logic                   last_byte,
	output      alt_pkg::tok_flags_t    flags,
	output      logic [COUNT_WIDTH-1:0] elem_count
);
	logic [3:0]             state_q, state_n;
	logic [2:0]             err_q, err_n;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic                   data, elem_open, elem_close, raise;
	logic [2:0]             raise_code;

	always_comb begin
		state_n    = state_q;
		data       = 1'b0;
		elem_open  = 1'b0;
		elem_close = 1'b0;
		raise      = 1'b0;
		raise_code = alt_pkg::ERR_NONE;
		case (state_q)
			alt_pkg::ST_BEGIN: begin
				if (text_byte == alt_pkg::CH_LBRACE)
					state_n = alt_pkg::ST_FIRSTVAL;
				else if (!alt_pkg::is_ws(text_byte)) begin
					raise      = 1'b1;
					raise_code = alt_pkg::ERR_BEFORE_BRACE;
				end
			end
			alt_pkg::ST_FIRSTVAL, alt_pkg::ST_FINDVAL: begin
				if (text_byte == alt_pkg::CH_LBRACE) begin
					raise      = 1'b1;
					raise_code = alt_pkg::ERR_NESTED;
				end else if (text_byte == alt_pkg::CH_DQUOTE) begin
					elem_open = 1'b1;
					state_n   = alt_pkg::ST_QUOTED;
				end else if (alt_pkg::bare_start_ok(text_byte)) begin
					elem_open = 1'b1;
					data      = 1'b1;
					state_n   = alt_pkg::ST_BARE;
				end else if (text_byte == alt_pkg::CH_RBRACE) begin
					// empty braces are fine, a trailing comma is not
					if (state_q == alt_pkg::ST_FIRSTVAL)
						state_n = alt_pkg::ST_FINISH;
					else begin
						raise      = 1'b1;
						raise_code = alt_pkg::ERR_EMPTY_ELEM;
					end
				end else if (text_byte == alt_pkg::CH_COMMA) begin
					raise      = 1'b1;
					raise_code = alt_pkg::ERR_EMPTY_ELEM;
				end else if (!alt_pkg::is_ws(text_byte)) begin
					raise      = 1'b1;
					raise_code = alt_pkg::ERR_ILLEGAL_START;
				end
			end
			alt_pkg::ST_BARE: begin
				if (text_byte == alt_pkg::CH_LBRACE) begin
					elem_close = 1'b1;
					raise      = 1'b1;
					raise_code = alt_pkg::ERR_BRACE_IN_VAL;
				end else if (text_byte == alt_pkg::CH_RBRACE) begin
					elem_close = 1'b1;
					state_n    = alt_pkg::ST_FINISH;
				end else if (text_byte == alt_pkg::CH_COMMA) begin
					elem_close = 1'b1;
					state_n    = alt_pkg::ST_FINDVAL;
				end else if (alt_pkg::is_ws(text_byte)) begin
					elem_close = 1'b1;
					state_n    = alt_pkg::ST_FINDCOMMA;
				end else
					data = 1'b1;
			end
			alt_pkg::ST_QUOTED: begin
				if (text_byte == alt_pkg::CH_DQUOTE) begin
					elem_close = 1'b1;
					state_n    = alt_pkg::ST_FINDCOMMA;
				end else begin
					data = 1'b1;
					if (text_byte == alt_pkg::CH_BSLASH)
						state_n = alt_pkg::ST_QESC;
				end
			end
			alt_pkg::ST_QESC: begin
				data    = 1'b1;
				state_n = alt_pkg::ST_QUOTED;
			end
			alt_pkg::ST_FINDCOMMA: begin
				if (text_byte == alt_pkg::CH_COMMA)
					state_n = alt_pkg::ST_FINDVAL;
				else if (text_byte == alt_pkg::CH_RBRACE)
					state_n = alt_pkg::ST_FINISH;
				else if (!alt_pkg::is_ws(text_byte)) begin
					raise      = 1'b1;
					raise_code = alt_pkg::ERR_AFTER_VALUE;
				end
			end
			alt_pkg::ST_FINISH: begin
				if (!alt_pkg::is_ws(text_byte)) begin
					raise      = 1'b1;
					raise_code = alt_pkg::ERR_AFTER_END;
				end
			end
			default: ;
		endcase

		if (raise)
			state_n = alt_pkg::ST_ERROR;
		err_n = (raise && err_q == alt_pkg::ERR_NONE) ? raise_code : err_q;
		cnt_n = (elem_open && !(&cnt_q)) ? cnt_q + 1'b1 : cnt_q;

		// an element still open on the last byte ends there
		if (last_byte && (state_n == alt_pkg::ST_BARE || state_n == alt_pkg::ST_QUOTED
				|| state_n == alt_pkg::ST_QESC))
			elem_close = 1'b1;

		flags.is_data    = data;
		flags.elem_begin = elem_open;
		flags.elem_end   = elem_close;
		flags.closed     = (state_n == alt_pkg::ST_FINISH) && (err_n == alt_pkg::ERR_NONE);
		flags.error_code = err_n;
		flags.done_res   = last_byte;
		elem_count       = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alt_pkg::ST_BEGIN;
			err_q   <= alt_pkg::ERR_NONE;
			cnt_q   <= '0;
		end else if (step) begin
			// the last byte returns the parser to its reset state
			if (last_byte) begin
				state_q <= alt_pkg::ST_BEGIN;
				err_q   <= alt_pkg::ERR_NONE;
				cnt_q   <= '0;
			end else begin
				state_q <= state_n;
				err_q   <= err_n;
				cnt_q   <= cnt_n;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/alt_checker.sv
// Port-level checks for array_literal_tokenizer_core, attached by bind.
// Depends on alt_pkg and on the top level's interface ports.
`default_nettype none
module alt_checker #(
	parameter int COUNT_WIDTH = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [7:0]             data_byte,
	input wire logic                   is_data,
	input wire logic                   elem_begin,
	input wire logic [COUNT_WIDTH-1:0] elem_count,
	input wire logic [2:0]             error_code,
	input wire logic                   done_res
);
	logic                   out_acc;
	logic                   seen_q;
	logic                   prev_done_q;
	logic [2:0]             prev_err_q;
	logic [COUNT_WIDTH-1:0] prev_cnt_q;

	assign out_acc = out_valid && out_ready;

	// remember the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			prev_done_q <= 1'b0;
			prev_err_q  <= alt_pkg::ERR_NONE;
			prev_cnt_q  <= '0;
		end else if (out_acc) begin
			seen_q      <= 1'b1;
			prev_done_q <= done_res;
			prev_err_q  <= error_code;
			prev_cnt_q  <= elem_count;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q && !prev_done_q && prev_err_q != alt_pkg::ERR_NONE
			|-> error_code == prev_err_q)
		else $error("error code changed within a text");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q && !prev_done_q
			|-> (elem_count == prev_cnt_q + COUNT_WIDTH'(elem_begin))
				|| (&prev_cnt_q && elem_count == prev_cnt_q))
		else $error("element count did not follow element openings");

	a_no_data_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (is_data || elem_begin) |-> error_code == alt_pkg::ERR_NONE)
		else $error("element activity reported after an error");

	a_quote_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && elem_begin && !is_data |-> data_byte == alt_pkg::CH_DQUOTE)
		else $error("non-data element opening on a byte other than a double quote");
endmodule

bind array_literal_tokenizer_core alt_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_alt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (tok_out.valid),
	.out_ready  (tok_out.ready),
	.data_byte  (tok_out.data_byte),
	.is_data    (tok_out.is_data),
	.elem_begin (tok_out.elem_begin),
	.elem_count (tok_out.elem_count),
	.error_code (tok_out.error_code),
	.done_res   (tok_out.done_res)
);
`default_nettype wire

// File: test/token_checker.sv
`timescale 1ns / 100ps
// Token result checker for the array literal tokenizer: predicts every result from the
// accepted text bytes and compares it field by field. Depends on alt_pkg and alt_if.sv.
module token_checker #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	alt_byte_if  text_if,
	alt_tok_if   tok_if,
	output int   mismatches,
	output int   pending
);
	import alt_pkg::*;

	typedef struct packed {
		logic [7:0]             data_byte;
		logic                   is_data;
		logic                   elem_begin;
		logic                   elem_end;
		logic [COUNT_WIDTH-1:0] elem_count;
		logic                   closed;
		logic [2:0]             error_code;
		logic                   done_res;
	} token_t;

	token_t expected_tokens[$];
	token_t predicted, wanted, observed;

	// parser copy kept alongside the block
	logic [3:0]             scan_state;
	logic [2:0]             scan_error;
	logic [COUNT_WIDTH-1:0] scan_count;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	task automatic raise_fault(input logic [2:0] code);
		if (scan_error == ERR_NONE)
			scan_error = code;
		scan_state = ST_ERROR;
	endtask

	task automatic predict_token(input logic [7:0] c, input logic last, output token_t t);
		t = '0;
		t.data_byte = c;
		case (scan_state)
			ST_BEGIN: begin
				if (c == CH_LBRACE)
					scan_state = ST_FIRSTVAL;
				else if (!is_blank(c))
					raise_fault(ERR_BEFORE_BRACE);
			end
			ST_FIRSTVAL, ST_FINDVAL: begin
				if (c == CH_LBRACE) begin
					raise_fault(ERR_NESTED);
				end else if (c == CH_DQUOTE) begin
					t.elem_begin = 1'b1;
					scan_state = ST_QUOTED;
				end else if (c == CH_RBRACE) begin
					if (scan_state == ST_FIRSTVAL)
						scan_state = ST_FINISH;
					else
						raise_fault(ERR_EMPTY_ELEM);
				end else if (c == CH_COMMA) begin
					raise_fault(ERR_EMPTY_ELEM);
				end else if (is_blank(c)) begin
					// skip separators
				end else if (c < CH_SPACE || c == CH_SQUOTE) begin
					raise_fault(ERR_ILLEGAL_START);
				end else begin
					t.elem_begin = 1'b1;
					t.is_data = 1'b1;
					scan_state = ST_BARE;
				end
			end
			ST_BARE: begin
				if (c == CH_LBRACE) begin
					t.elem_end = 1'b1;
					raise_fault(ERR_BRACE_IN_VAL);
				end else if (c == CH_RBRACE) begin
					t.elem_end = 1'b1;
					scan_state = ST_FINISH;
				end else if (c == CH_COMMA) begin
					t.elem_end = 1'b1;
					scan_state = ST_FINDVAL;
				end else if (is_blank(c)) begin
					t.elem_end = 1'b1;
					scan_state = ST_FINDCOMMA;
				end else begin
					t.is_data = 1'b1;
				end
			end
			ST_QUOTED: begin
				if (c == CH_DQUOTE) begin
					t.elem_end = 1'b1;
					scan_state = ST_FINDCOMMA;
				end else begin
					t.is_data = 1'b1;
					if (c == CH_BSLASH)
						scan_state = ST_QESC;
				end
			end
			ST_QESC: begin
				t.is_data = 1'b1;
				scan_state = ST_QUOTED;
			end
			ST_FINDCOMMA: begin
				if (c == CH_COMMA)
					scan_state = ST_FINDVAL;
				else if (c == CH_RBRACE)
					scan_state = ST_FINISH;
				else if (!is_blank(c))
					raise_fault(ERR_AFTER_VALUE);
			end
			ST_FINISH: begin
				if (!is_blank(c))
					raise_fault(ERR_AFTER_END);
			end
			default: ;
		endcase

		// saturate the element count
		if (t.elem_begin && scan_count != '1)
			scan_count = scan_count + 1'b1;
		// close an element still open at the end of the text
		if (last && (scan_state == ST_BARE || scan_state == ST_QUOTED || scan_state == ST_QESC))
			t.elem_end = 1'b1;

		t.elem_count = scan_count;
		t.closed = (scan_state == ST_FINISH) && (scan_error == ERR_NONE);
		t.error_code = scan_error;
		t.done_res = last;

		if (last) begin
			scan_state = ST_BEGIN;
			scan_error = ERR_NONE;
			scan_count = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state = ST_BEGIN;
			scan_error = ERR_NONE;
			scan_count = '0;
			expected_tokens.delete();
			pending <= 0;
		end else begin
			if (text_if.valid && text_if.ready) begin
				predict_token(text_if.text_byte, text_if.last_byte, predicted);
				expected_tokens.push_back(predicted);
			end
			if (tok_if.valid && tok_if.ready) begin
				observed.data_byte = tok_if.data_byte;
				observed.is_data = tok_if.is_data;
				observed.elem_begin = tok_if.elem_begin;
				observed.elem_end = tok_if.elem_end;
				observed.elem_count = tok_if.elem_count;
				observed.closed = tok_if.closed;
				observed.error_code = tok_if.error_code;
				observed.done_res = tok_if.done_res;
				if (expected_tokens.size() == 0) begin
					$error("unexpected result item, data_byte %0h", observed.data_byte);
					mismatches++;
				end else begin
					wanted = expected_tokens.pop_front();
					check_field("data_byte", wanted.data_byte, observed.data_byte);
					check_field("is_data", wanted.is_data, observed.is_data);
					check_field("elem_begin", wanted.elem_begin, observed.elem_begin);
					check_field("elem_end", wanted.elem_end, observed.elem_end);
					check_field("elem_count", wanted.elem_count, observed.elem_count);
					check_field("closed", wanted.closed, observed.closed);
					check_field("error_code", wanted.error_code, observed.error_code);
					check_field("done_res", wanted.done_res, observed.done_res);
				end
			end
			pending <= expected_tokens.size();
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Top of the array literal tokenizer testbench: clock, reset, text stimulus and verdict.
// Depends on alt_pkg, alt_if.sv, array_literal_tokenizer_core and token_checker.
module tb_top;
	import alt_pkg::*;

	localparam int CW = 16;
	localparam int RANDOM_BYTES = 1450;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   idle_pct;
	int   stall_pct;
	int   sent_bytes;
	logic [7:0] text_buf[$];

	alt_byte_if text_if();
	alt_tok_if #(.COUNT_WIDTH(CW)) tok_if();

	array_literal_tokenizer_core #(.COUNT_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(text_if),
		.tok_out(tok_if)
	);

	token_checker #(.COUNT_WIDTH(CW)) u_token_checker (
		.clk(clk),
		.arst_n(arst_n),
		.text_if(text_if),
		.tok_if(tok_if),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		tok_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [7:0] blank_byte();
		int unsigned k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : 8'(9 + k);
	endfunction

	// bytes allowed in a bare value; the first one may not be a quote or a control byte
	function automatic logic [7:0] bare_byte(input bit first);
		logic [7:0] b;
		do begin
			b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(33, 126));
		end while (b == CH_LBRACE || b == CH_RBRACE || b == CH_COMMA || b == CH_SPACE ||
			(b >= 8'd9 && b <= 8'd13) ||
			(first && (b < CH_SPACE || b == CH_DQUOTE || b == CH_SQUOTE)));
		return b;
	endfunction

	task automatic build_text();
		int unsigned n_elems, len, e, pos;
		logic [7:0] b;
		text_buf.delete();
		// plain noise now and then
		if ($urandom_range(99) < 10) begin
			len = $urandom_range(1, 12);
			repeat (len) text_buf.push_back(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(3) == 0)
			text_buf.push_back(blank_byte());
		text_buf.push_back(CH_LBRACE);
		n_elems = $urandom_range(0, 5);
		for (e = 0; e < n_elems; e++) begin
			if ($urandom_range(2) == 0)
				text_buf.push_back(blank_byte());
			len = $urandom_range(0, 5);
			if ($urandom_range(1)) begin
				text_buf.push_back(CH_DQUOTE);
				repeat (len) begin
					if ($urandom_range(4) == 0) begin
						text_buf.push_back(CH_BSLASH);
						text_buf.push_back(8'($urandom_range(255)));
					end else begin
						b = 8'($urandom_range(255));
						if (b == CH_DQUOTE || b == CH_BSLASH)
							b = 8'h71;
						text_buf.push_back(b);
					end
				end
				text_buf.push_back(CH_DQUOTE);
			end else begin
				text_buf.push_back(bare_byte(1'b1));
				repeat (len) text_buf.push_back(bare_byte(1'b0));
			end
			if ($urandom_range(2) == 0)
				text_buf.push_back(blank_byte());
			if (e != n_elems - 1)
				text_buf.push_back(CH_COMMA);
		end
		// leave the array unclosed once in a while
		if ($urandom_range(9) != 0)
			text_buf.push_back(CH_RBRACE);
		if ($urandom_range(3) == 0)
			text_buf.push_back(blank_byte());
		// break about one text in five
		if ($urandom_range(4) == 0) begin
			pos = $urandom_range(text_buf.size() - 1);
			case ($urandom_range(2))
				0: text_buf[pos] = 8'($urandom_range(255));
				1: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
				default: begin
					case ($urandom_range(6))
						0: b = CH_LBRACE;
						1: b = CH_RBRACE;
						2: b = CH_COMMA;
						3: b = CH_DQUOTE;
						4: b = CH_SQUOTE;
						5: b = CH_BSLASH;
						default: b = 8'h00;
					endcase
					text_buf.insert(pos, b);
				end
			endcase
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < idle_pct) begin
			text_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		text_if.valid <= 1'b1;
		text_if.text_byte <= b;
		text_if.last_byte <= last;
		@(posedge clk);
		while (!text_if.ready) @(posedge clk);
		sent_bytes++;
	endtask

	task automatic send_text();
		int unsigned i;
		for (i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	// hold the sender until every expected result is back
	task automatic drain();
		text_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int phase, base;
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.text_byte = 8'h00;
		text_if.last_byte = 1'b0;
		tok_if.ready = 1'b0;
		idle_pct = 18;
		stall_pct = 67;
		sent_bytes = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte before the brace
		text_buf = '{8'h78};
		send_text();
		// nested brace
		text_buf = '{CH_LBRACE, CH_LBRACE};
		send_text();
		// empty element
		text_buf = '{CH_LBRACE, CH_COMMA};
		send_text();
		// zero byte and single quote cannot start a value
		text_buf = '{CH_LBRACE, 8'h00};
		send_text();
		text_buf = '{CH_LBRACE, CH_SQUOTE};
		send_text();
		// brace inside a bare value ends it with an error
		text_buf = '{CH_LBRACE, 8'h61, CH_LBRACE};
		send_text();
		// junk after the closing brace
		text_buf = '{CH_LBRACE, CH_RBRACE, CH_RBRACE};
		send_text();
		// escaped quote, then junk after the value
		text_buf = '{CH_LBRACE, CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_DQUOTE, CH_SPACE, 8'h7A};
		send_text();
		// control and high bytes in a bare value still open at the last byte
		text_buf = '{CH_LBRACE, 8'h61, 8'h01, 8'hFF};
		send_text();
		drain();

		base = sent_bytes;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					idle_pct = 18;
					stall_pct = 67;
				end
				1: begin
					idle_pct = 67;
					stall_pct = 18;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			while (sent_bytes - base < RANDOM_BYTES * (phase + 1) / 3) begin
				build_text();
				send_text();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
hdl/alt_pkg.sv
hdl/alt_if.sv
hdl/alt_parser.sv
hdl/array_literal_tokenizer_core.sv
hdl/alt_checker.sv
test/token_checker.sv
test/tb_top.sv
